@@ rtl/core/sira_pkg.sv @@
// Package for the signed integer to radix text converter.
// Holds the sequencer state type, radix limits, character constants, the digit mapping and the radix clamp.
// No dependencies.
package sira_pkg;

	localparam int unsigned RADIX_W = 6;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	// Register indexes
	localparam logic REG_RADIX = 1'b0;

	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_LETTER = 8'h37;  // '0' + 7, so that ten maps to 'A'
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_RD,
		ST_OUT
	} sira_state_t;

	function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [7:0] d8;
		d8 = {2'b00, d};
		return (d > DIGIT_MAX) ? d8 + CHAR_LETTER : d8 + CHAR_ZERO;
	endfunction

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

endpackage

@@ rtl/core/sira_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the digit values of one conversion. No dependencies.
module sira_ram #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/signed_integer_to_radix_ascii_top.sv @@
// Top level of the signed integer to radix text converter.
// Uses sira_pkg and the digit store sira_ram.
//
// Takes one signed VALUE_WIDTH-bit integer and sends its text in the base held in the radix
// register (byte address 0, bits 5:0, reset 10; values below 2 act as 2, above 36 as 36), most
// significant character first, a '-' ahead of negative values, last set on the final character.
// Digits come from one bit-serial restoring divider that yields a quotient bit per cycle, and
// each digit character is then read back from the digit store and loaded into the output
// register, a sign being loaded directly; output stalls hold either. The input stalls for the
// whole conversion and is released once the final character sits in the output register.
module signed_integer_to_radix_ascii_top
	import sira_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    character,
	output logic                          last
);

	localparam int unsigned AW = $clog2(VALUE_WIDTH);
	localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);
	localparam logic [AW-1:0] BIT_TOP = AW'(VALUE_WIDTH - 1);

	sira_state_t state_q, state_d;

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     base_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [AW-1:0]          bit_q;
	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          rd_idx_q;
	logic                   neg_q;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;

	logic                   in_xfer;
	logic                   out_free;
	logic [RADIX_W:0]       trial;
	logic [RADIX_W:0]       diff;
	logic                   qbit;
	logic [RADIX_W-1:0]     rem_next;
	logic [VALUE_WIDTH-1:0] mag_next;
	logic [VALUE_WIDTH-1:0] raw;
	logic                   ram_we;
	logic                   ram_re;
	logic [RADIX_W-1:0]     ram_rdata;
	logic                   load_out;
	logic [7:0]             char_d;
	logic                   last_d;
	logic                   cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_RADIX) begin
			prdata = {{(32-RADIX_W){1'b0}}, radix_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr && paddr[2] == REG_RADIX) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	// Shared divider step: one quotient bit per cycle
	assign trial    = {rem_q, mag_q[VALUE_WIDTH-1]};
	assign diff     = trial - {1'b0, base_q};
	assign qbit     = (trial >= {1'b0, base_q});
	assign rem_next = qbit ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
	assign mag_next = {mag_q[VALUE_WIDTH-2:0], qbit};

	assign raw      = value;
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		load_out = 1'b0;
		char_d   = CHAR_MINUS;
		last_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (bit_q == '0) begin
					ram_we = 1'b1;
					if (mag_next == '0) begin
						state_d = neg_q ? ST_SIGN : ST_RD;
					end
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_RD;
				end
			end
			ST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				char_d = digit_char(ram_rdata);
				last_d = (rd_idx_q == '0);
				if (out_free) begin
					load_out = 1'b1;
					state_d  = (rd_idx_q == '0) ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer counters and divider registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			bit_q    <= BIT_TOP;
			rd_idx_q <= '0;
			neg_q    <= 1'b0;
		end else begin
			if (in_xfer) begin
				cnt_q <= '0;
				bit_q <= BIT_TOP;
				neg_q <= raw[VALUE_WIDTH-1];
			end else if (state_q == ST_DIV) begin
				if (bit_q == '0) begin
					cnt_q    <= cnt_q + 1'b1;
					rd_idx_q <= cnt_q[AW-1:0];
					bit_q    <= BIT_TOP;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end else if (state_q == ST_OUT && out_free && rd_idx_q != '0) begin
				rd_idx_q <= rd_idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q  <= raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
			rem_q  <= '0;
			base_q <= clamp_radix(radix_q);
		end else if (state_q == ST_DIV) begin
			mag_q <= mag_next;
			// Restart the remainder for the next digit
			rem_q <= (bit_q == '0) ? '0 : rem_next;
		end
	end

	sira_ram #(
		.WIDTH (RADIX_W),
		.DEPTH (VALUE_WIDTH)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rem_next),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// Output register: hold while stalled, drop valid after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	// Checks
	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < base_q))
		else $error("divider remainder not below base");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (base_q >= RADIX_MIN && base_q <= RADIX_MAX))
		else $error("base out of range during conversion");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(VALUE_WIDTH))
		else $error("digit count exceeds value width");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free && rd_idx_q == '0) |=> (out_valid_q && last_q))
		else $error("final character not flagged last");

endmodule
